[rtl/core/hmac_sha1_drbg_macros.svh]
// assertion macros for the drbg rtl
// no dependencies; each use sits inside a module that has aclk and aresetn
`ifndef HMAC_SHA1_DRBG_MACROS_SVH
`define HMAC_SHA1_DRBG_MACROS_SVH

// invariant that holds at every edge out of reset
`define HDRBG_CHECK(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// same-cycle implication
`define HDRBG_IMPLIES(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) else $error(msg);

`endif

[rtl/core/hdrbg_pkg.sv]
// shared types and constants of the hmac-sha1 drbg
// no dependencies
package hdrbg_pkg;

    localparam logic [1:0] OP_INST   = 2'd0;
    localparam logic [1:0] OP_RESEED = 2'd1;
    localparam logic [1:0] OP_GEN    = 2'd2;

    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    localparam logic [7:0] IPAD_BYTE = 8'h36;
    localparam logic [7:0] OPAD_BYTE = 8'h5c;

    localparam logic [159:0] SHA_IV =
        160'h67452301_efcdab89_98badcfe_10325476_c3d2e1f0;
    localparam logic [159:0] V_RESET = {20{8'h01}};

    // controller to datapath
    typedef struct packed {
        logic       hinit;
        logic       msg_begin;
        logic       pad_blk;
        logic       opad;
        logic       src_dig;
        logic       sep_en;
        logic       sep_val;
        logic       use_seed;
        logic       load_go;
        logic       comp_go;
        logic       save_dig;
        logic       wr_k;
        logic       wr_v;
        logic       preset;
        logic       seed_wr;
        logic       seed_clr;
        logic       out_en;
        logic [4:0] out_idx;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic load_done;
        logic comp_done;
        logic more;
        logic seed_full;
        logic seed_empty;
        logic seed_ovf;
    } sts_t;

    // byte idx of a 160-bit big-endian value
    function automatic logic [7:0] pick_byte(input logic [159:0] w, input logic [4:0] idx);
        logic [159:0] s;
        s = w << {idx, 3'b000};
        return s[159:152];
    endfunction

endpackage

[rtl/core/hdrbg_ram.sv]
// generic single-write, single-read ram with registered read
// no dependencies
module hdrbg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/core/hdrbg_sha1.sv]
// sha-1 compression unit, one round per cycle, holds the chaining value
// depends on hdrbg_pkg
module hdrbg_sha1 (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         init,
    input  logic         start,
    input  logic [511:0] block,
    output logic         done,
    output logic [159:0] digest
);
    import hdrbg_pkg::*;

    logic [159:0] h_reg;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  w_reg [16];
    logic [6:0]   rnd_reg;
    logic         busy_reg, done_reg;
    logic [31:0]  f, k, t, w_new, w_x;

    always_comb begin
        if (rnd_reg < 7'd20) begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = 32'h5a827999;
        end else if (rnd_reg < 7'd40) begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'h6ed9eba1;
        end else if (rnd_reg < 7'd60) begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = 32'h8f1bbcdc;
        end else begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'hca62c1d6;
        end
        t     = {a_reg[26:0], a_reg[31:27]} + f + e_reg + k + w_reg[0];
        w_x   = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        w_new = {w_x[30:0], w_x[31]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
            h_reg    <= SHA_IV;
        end else begin
            done_reg <= 1'b0;
            if (init) begin
                h_reg <= SHA_IV;
            end
            if (start) begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
                {a_reg, b_reg, c_reg, d_reg, e_reg} <= h_reg;
                for (int i = 0; i < 16; i++) begin
                    w_reg[i] <= block[511-32*i -: 32];
                end
            end else if (busy_reg) begin
                if (rnd_reg == 7'd80) begin
                    // feed-forward into the chaining value
                    h_reg <= {h_reg[159:128] + a_reg, h_reg[127:96] + b_reg,
                              h_reg[95:64] + c_reg, h_reg[63:32] + d_reg,
                              h_reg[31:0] + e_reg};
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    a_reg <= t;
                    b_reg <= a_reg;
                    c_reg <= {b_reg[1:0], b_reg[31:2]};
                    d_reg <= c_reg;
                    e_reg <= d_reg;
                    for (int i = 0; i < 15; i++) begin
                        w_reg[i] <= w_reg[i+1];
                    end
                    w_reg[15] <= w_new;
                    rnd_reg   <= rnd_reg + 7'd1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign digest = h_reg;
endmodule

[rtl/core/hdrbg_dp.sv]
// drbg datapath: key and value registers, seed store, block builder, sha-1 unit
// depends on hdrbg_pkg, hdrbg_ram, hdrbg_sha1
module hdrbg_dp #(
    parameter int MAX_SEED_BYTES = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  hdrbg_pkg::cmd_t   cmd,
    input  logic [7:0]        seed_byte,
    output hdrbg_pkg::sts_t   sts,
    output logic [7:0]        out_byte
);
    import hdrbg_pkg::*;

    localparam int AW = (MAX_SEED_BYTES > 1) ? $clog2(MAX_SEED_BYTES) : 1;
    localparam int LW = $clog2(MAX_SEED_BYTES + 1);
    localparam int PW = $clog2(MAX_SEED_BYTES + 101);
    localparam int BW = PW + 3;

    logic [159:0] k_reg, v_reg, dig_reg;
    logic [LW-1:0] len_reg;
    logic          ovf_reg;
    logic [511:0]  blk_reg;
    logic [PW-1:0] p_reg;
    logic [5:0]    cnt_reg;
    logic          phase_reg, busy_reg, ldone_reg;
    logic          padblk_reg, opad_reg, srcdig_reg, sepen_reg, sepval_reg, useseed_reg;

    logic          full;
    logic [7:0]    ram_rdata;
    logic [PW-1:0] n_ext, msg_len, pad_end, len_start, seed_end;
    logic [BW-1:0] bitlen;
    logic [63:0]   blen64;
    logic [2:0]    lj;
    logic [159:0]  src;
    logic [7:0]    nbyte;
    logic          comp_done;
    logic [159:0]  digest;

    assign full = (len_reg == LW'(MAX_SEED_BYTES));

    hdrbg_ram #(.WIDTH(8), .DEPTH(MAX_SEED_BYTES)) u_seed_ram (
        .aclk  (aclk),
        .we    (cmd.seed_wr && !full && !cmd.seed_clr),
        .waddr (AW'(len_reg)),
        .wdata (seed_byte),
        .raddr (AW'(p_reg - PW'(21))),
        .rdata (ram_rdata)
    );

    hdrbg_sha1 u_sha1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .init    (cmd.hinit),
        .start   (cmd.comp_go),
        .block   (blk_reg),
        .done    (comp_done),
        .digest  (digest)
    );

    // message geometry: key pad block, or src, optional separator and seed, padding
    always_comb begin
        n_ext     = useseed_reg ? PW'(len_reg) : '0;
        msg_len   = PW'(20) + (sepen_reg ? (PW'(1) + n_ext) : '0);
        pad_end   = (msg_len + PW'(72)) & ~PW'(63);
        len_start = pad_end - PW'(8);
        seed_end  = PW'(21) + n_ext;
        bitlen    = (BW'(msg_len) + BW'(64)) << 3;
        blen64    = 64'(bitlen);
        lj        = 3'(p_reg - len_start);
        src       = srcdig_reg ? dig_reg : v_reg;
        if (padblk_reg) begin
            nbyte = (p_reg < PW'(20)) ? pick_byte(k_reg, p_reg[4:0]) : 8'h00;
            nbyte = nbyte ^ (opad_reg ? OPAD_BYTE : IPAD_BYTE);
        end else if (p_reg < PW'(20)) begin
            nbyte = pick_byte(src, p_reg[4:0]);
        end else if (sepen_reg && p_reg == PW'(20)) begin
            nbyte = {7'd0, sepval_reg};
        end else if (sepen_reg && p_reg < seed_end) begin
            nbyte = ram_rdata;
        end else if (p_reg == msg_len) begin
            nbyte = 8'h80;
        end else if (p_reg >= len_start) begin
            nbyte = blen64[63 - 8*lj -: 8];
        end else begin
            nbyte = 8'h00;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg     <= '0;
            v_reg     <= V_RESET;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            busy_reg  <= 1'b0;
            ldone_reg <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
            p_reg     <= '0;
        end else begin
            ldone_reg <= 1'b0;
            if (cmd.seed_clr) begin
                len_reg <= '0;
                ovf_reg <= 1'b0;
            end else if (cmd.seed_wr) begin
                if (full) begin
                    ovf_reg <= 1'b1;
                end else begin
                    len_reg <= len_reg + LW'(1);
                end
            end
            if (cmd.preset) begin
                k_reg <= '0;
                v_reg <= V_RESET;
            end
            if (cmd.wr_k) begin
                k_reg <= digest;
            end
            if (cmd.wr_v) begin
                v_reg <= digest;
            end
            if (cmd.save_dig) begin
                dig_reg <= digest;
            end
            if (cmd.msg_begin) begin
                p_reg       <= '0;
                padblk_reg  <= cmd.pad_blk;
                opad_reg    <= cmd.opad;
                srcdig_reg  <= cmd.src_dig;
                sepen_reg   <= cmd.sep_en;
                sepval_reg  <= cmd.sep_val;
                useseed_reg <= cmd.use_seed;
            end
            if (cmd.load_go) begin
                busy_reg  <= 1'b1;
                phase_reg <= 1'b0;
                cnt_reg   <= '0;
            end else if (busy_reg) begin
                // phase 0 presents the ram address, phase 1 takes the byte
                phase_reg <= !phase_reg;
                if (phase_reg) begin
                    blk_reg <= {blk_reg[503:0], nbyte};
                    p_reg   <= p_reg + PW'(1);
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63) begin
                        busy_reg  <= 1'b0;
                        ldone_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign sts.load_done  = ldone_reg;
    assign sts.comp_done  = comp_done;
    assign sts.more       = (p_reg < pad_end);
    assign sts.seed_full  = full;
    assign sts.seed_empty = (len_reg == '0);
    assign sts.seed_ovf   = ovf_reg;
    assign out_byte = cmd.out_en ? pick_byte(v_reg, cmd.out_idx) : 8'h00;
endmodule

[rtl/core/hdrbg_ctrl.sv]
// drbg sequencer: handshakes, hmac block sequencing, update rounds, output bytes
// depends on hdrbg_pkg and hmac_sha1_drbg_macros.svh
`include "hmac_sha1_drbg_macros.svh"
module hdrbg_ctrl #(
    parameter int MAX_REQUEST_BYTES = 64
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [1:0]      s_op,
    input  logic            s_has_byte,
    input  logic            s_last,
    input  logic [6:0]      s_byte_count,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [1:0]      m_kind,
    output logic            m_final,
    output hdrbg_pkg::cmd_t cmd,
    input  hdrbg_pkg::sts_t sts
);
    import hdrbg_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_HBEGIN = 3'd1;
    localparam logic [2:0] ST_LWAIT  = 3'd2;
    localparam logic [2:0] ST_CWAIT  = 3'd3;
    localparam logic [2:0] ST_HDONE  = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;
    localparam logic [2:0] ST_RES    = 3'd6;

    localparam logic [1:0] JOB_UPD_K = 2'd0;
    localparam logic [1:0] JOB_UPD_V = 2'd1;
    localparam logic [1:0] JOB_GEN_V = 2'd2;

    logic [2:0] state_reg, state_next;
    logic [1:0] job_reg, job_next;
    logic       outer_reg, outer_next, padblk_reg, padblk_next;
    logic       round_reg, round_next, useseed_reg, useseed_next;
    logic       seeding_reg, seeding_next;
    logic [1:0] kind_reg, kind_next;
    logic [6:0] rem_reg, rem_next, req;
    logic [4:0] bi_reg, bi_next;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        job_next     = job_reg;
        outer_next   = outer_reg;
        padblk_next  = padblk_reg;
        round_next   = round_reg;
        useseed_next = useseed_reg;
        seeding_next = seeding_reg;
        kind_next    = kind_reg;
        rem_next     = rem_reg;
        bi_next      = bi_reg;
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;
        m_kind       = KIND_BYTE;
        m_final      = 1'b0;
        req = (s_byte_count > 7'(MAX_REQUEST_BYTES)) ? 7'(MAX_REQUEST_BYTES) : s_byte_count;
        cmd.out_idx  = bi_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    outer_next = 1'b0;
                    round_next = 1'b0;
                    job_next   = JOB_UPD_K;
                    if (s_op == OP_INST || s_op == OP_RESEED) begin
                        cmd.seed_wr = s_has_byte;
                        if (s_last) begin
                            if (sts.seed_ovf || (s_has_byte && sts.seed_full)) begin
                                cmd.seed_clr = 1'b1;
                                kind_next    = KIND_REJECT;
                                state_next   = ST_RES;
                            end else begin
                                cmd.preset   = (s_op == OP_INST);
                                useseed_next = 1'b1;
                                seeding_next = 1'b1;
                                state_next   = ST_HBEGIN;
                            end
                        end
                    end else if (s_op == OP_GEN) begin
                        useseed_next = 1'b0;
                        seeding_next = 1'b0;
                        state_next   = ST_HBEGIN;
                        if (req != 7'd0) begin
                            rem_next = req;
                            bi_next  = '0;
                            job_next = JOB_GEN_V;
                        end
                    end
                end
            end
            ST_HBEGIN: begin
                cmd.hinit     = 1'b1;
                cmd.msg_begin = 1'b1;
                cmd.pad_blk   = 1'b1;
                cmd.opad      = outer_reg;
                cmd.load_go   = 1'b1;
                padblk_next   = 1'b1;
                state_next    = ST_LWAIT;
            end
            ST_LWAIT: begin
                if (sts.load_done) begin
                    cmd.comp_go = 1'b1;
                    state_next  = ST_CWAIT;
                end
            end
            ST_CWAIT: begin
                if (sts.comp_done) begin
                    if (padblk_reg) begin
                        padblk_next   = 1'b0;
                        cmd.msg_begin = 1'b1;
                        cmd.src_dig   = outer_reg;
                        cmd.sep_en    = !outer_reg && (job_reg == JOB_UPD_K);
                        cmd.sep_val   = round_reg;
                        cmd.use_seed  = useseed_reg;
                        cmd.load_go   = 1'b1;
                        state_next    = ST_LWAIT;
                    end else if (sts.more) begin
                        cmd.load_go = 1'b1;
                        state_next  = ST_LWAIT;
                    end else if (!outer_reg) begin
                        cmd.save_dig = 1'b1;
                        outer_next   = 1'b1;
                        state_next   = ST_HBEGIN;
                    end else begin
                        cmd.wr_k   = (job_reg == JOB_UPD_K);
                        cmd.wr_v   = (job_reg != JOB_UPD_K);
                        outer_next = 1'b0;
                        state_next = ST_HDONE;
                    end
                end
            end
            ST_HDONE: begin
                priority if (job_reg == JOB_UPD_K) begin
                    job_next   = JOB_UPD_V;
                    state_next = ST_HBEGIN;
                end else if (job_reg == JOB_GEN_V) begin
                    state_next = ST_OUT;
                end else if (!round_reg && useseed_reg && !sts.seed_empty) begin
                    // second round with separator one for a non-empty seed
                    round_next = 1'b1;
                    job_next   = JOB_UPD_K;
                    state_next = ST_HBEGIN;
                end else if (seeding_reg) begin
                    cmd.seed_clr = 1'b1;
                    kind_next    = KIND_DONE;
                    state_next   = ST_RES;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                m_tvalid   = 1'b1;
                m_final    = (rem_reg == 7'd1);
                cmd.out_en = 1'b1;
                if (m_tready) begin
                    if (rem_reg == 7'd1) begin
                        job_next     = JOB_UPD_K;
                        round_next   = 1'b0;
                        useseed_next = 1'b0;
                        seeding_next = 1'b0;
                        state_next   = ST_HBEGIN;
                    end else begin
                        rem_next = rem_reg - 7'd1;
                        if (bi_reg == 5'd19) begin
                            bi_next    = '0;
                            job_next   = JOB_GEN_V;
                            state_next = ST_HBEGIN;
                        end else begin
                            bi_next = bi_reg + 5'd1;
                        end
                    end
                end
            end
            ST_RES: begin
                m_tvalid = 1'b1;
                m_kind   = kind_reg;
                m_final  = 1'b1;
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            job_reg     <= JOB_UPD_K;
            outer_reg   <= 1'b0;
            padblk_reg  <= 1'b0;
            round_reg   <= 1'b0;
            useseed_reg <= 1'b0;
            seeding_reg <= 1'b0;
            kind_reg    <= KIND_DONE;
            rem_reg     <= '0;
            bi_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            job_reg     <= job_next;
            outer_reg   <= outer_next;
            padblk_reg  <= padblk_next;
            round_reg   <= round_next;
            useseed_reg <= useseed_next;
            seeding_reg <= seeding_next;
            kind_reg    <= kind_next;
            rem_reg     <= rem_next;
            bi_reg      <= bi_next;
        end
    end

    `HDRBG_CHECK(a_one_side, !(s_tready && m_tvalid), "input taken while a word is pending")
    `HDRBG_CHECK(a_go_excl, !(cmd.load_go && cmd.comp_go), "load and compress started together")
    `HDRBG_IMPLIES(a_load_wait, sts.load_done, state_reg == ST_LWAIT, "block load ended unexpected")
    `HDRBG_IMPLIES(a_comp_wait, sts.comp_done, state_reg == ST_CWAIT, "compression ended unexpected")
endmodule

[rtl/core/hmac_sha1_drbg.sv]
// top level of the hmac-sha1 drbg: stream ports, sequencer and datapath
// depends on hdrbg_pkg, hdrbg_ctrl, hdrbg_dp
//
// hmac_drbg over sha-1 without additional input or prediction resistance.
// seed words (tuser 0 instantiate, 1 reseed) are taken back to back and
// buffered; the word with tlast seeds the generator and answers one status
// word (tuser 1 done, 2 rejected because the seed overran the buffer).
// a generate word (tuser 2) returns the requested number of random bytes,
// capped at MAX_REQUEST_BYTES, the last one flagged with tlast, then
// refreshes k and v internally. timing is set by the single sha-1 unit:
// every 64-byte block is assembled byte by byte, with an address phase and
// a take phase per byte since the seed ram read is registered, and then
// compressed. one hmac of a 20-byte value is four blocks; a seeding update
// costs two hmacs per round (one round for an empty seed, two otherwise,
// a longer seed adding blocks to the k hmacs), and a generate costs one
// hmac per 20 output bytes plus a one-round update at the end. while that
// work runs the block takes no new word.
module hmac_sha1_drbg #(
    parameter int MAX_SEED_BYTES    = 128,
    parameter int MAX_REQUEST_BYTES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // data_byte [7:0], has_byte [8], byte_count [15:9]
    input  logic        s_tlast,   // seed_last
    input  logic [1:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte [7:0]
    output logic        m_tlast,   // final_res
    output logic [1:0]  m_tuser    // kind
);
    import hdrbg_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer: handshakes and the hmac block schedule
    hdrbg_ctrl #(.MAX_REQUEST_BYTES(MAX_REQUEST_BYTES)) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_op         (s_tuser),
        .s_has_byte   (s_tdata[8]),
        .s_last       (s_tlast),
        .s_byte_count (s_tdata[15:9]),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_kind       (m_tuser),
        .m_final      (m_tlast),
        .cmd          (cmd),
        .sts          (sts)
    );

    // datapath: k, v, seed store and the sha-1 unit
    hdrbg_dp #(.MAX_SEED_BYTES(MAX_SEED_BYTES)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .seed_byte (s_tdata[7:0]),
        .sts       (sts),
        .out_byte  (m_tdata)
    );
endmodule
